/* sv/ilid_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list insert/delete unit: shared package
// Field widths, stream packing, command codes, sequencer states and the
// result record that passes from the sequencer to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

    localparam int FUNC_W      = 2;
    localparam int POS_W       = 7;
    localparam int DATA_W      = 32;
    localparam int LEN_OUT_W   = 7;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_REMOVE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SHIFT,
        ST_PLACE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 error;
        logic [LEN_OUT_W-1:0] length_after;
        logic [DATA_W-1:0]    read_data;
    } result_t;

endpackage

`default_nettype wire

/* sv/indexed_list_insert_delete_unit.sv */
// ----------------------------------------------------------------------------
// Indexed list insert/delete unit
// Ordered list of signed 32-bit values addressed by position, with read,
// overwrite, insert-before and remove commands.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the s_ stream: s_tuser carries the operation,
// s_tdata the position and the value. Every command returns exactly one beat
// on the m_ stream with the value read, the element count after the command
// and an error flag. A rejected command leaves the list unchanged.
// The sequencer takes one command at a time. A read passes through the
// execute and read-wait states, and an overwrite or an append writes in
// the execute state. An insert moves each element from the last one down
// to the position up by one place and then writes the new value; a remove
// moves each element after the position down by one place. Each shifted
// element needs one pass through the single read port and single write
// port of the element store. A new command is taken only once the result
// has gone to the output register and the sequencer is idle again.
// The result sits in an output register, so a new command is taken while
// an earlier result waits; when the receiver stalls with a result still
// held, the next command completes and then waits until the register frees.
// Reset empties the list; stored values are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete_unit
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // position [6:0], data_in [38:7], zero [39]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // func [1:0]
    input  wire logic [FUNC_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // read_data [31:0], length_after [38:32], error [39]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);

    logic              res_valid;
    logic              res_free;
    result_t           res;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    ilid_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .LEN_W    (LEN_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (s_tvalid),
        .cmd_ready   (s_tready),
        .cmd_func    (func_t'(s_tuser)),
        .cmd_pos     (s_tdata[POS_W-1:0]),
        .cmd_data    (s_tdata[POS_W +: DATA_W]),
        .res_valid   (res_valid),
        .res_free    (res_free),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ilid_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign res_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_free) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

`default_nettype wire

/* sv/ilid_mem.sv */
// ----------------------------------------------------------------------------
// Indexed list insert/delete unit: element store
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_mem
    import ilid_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/ilid_ctrl.sv */
// ----------------------------------------------------------------------------
// Indexed list insert/delete unit: command sequencer
// Checks each command against the element count and drives the element
// store; insert and remove move one element per cycle through the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_ctrl
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int ADDR_W   = 6,
    parameter int LEN_W    = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire func_t             cmd_func,
    input  wire logic [POS_W-1:0]  cmd_pos,
    input  wire logic [DATA_W-1:0] cmd_data,
    output logic                   res_valid,
    input  wire logic              res_free,
    output result_t                res,
    output logic                   mem_wr_en,
    output logic      [ADDR_W-1:0] mem_wr_addr,
    output logic      [DATA_W-1:0] mem_wr_data,
    output logic                   mem_rd_en,
    output logic      [ADDR_W-1:0] mem_rd_addr,
    input  wire logic [DATA_W-1:0] mem_rd_data
);

    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    func_t             func_reg, func_next;
    logic [CMP_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] rdv_reg, rdv_next;
    logic              err_reg, err_next;

    logic [CMP_W-1:0]  len_ext;
    logic [LEN_W-1:0]  len_m1;
    logic [ADDR_W-1:0] len_m1_a;
    logic [ADDR_W-1:0] pos_a;
    logic              cmd_err;
    logic              ins_append;
    logic              rem_last;

    assign len_ext    = CMP_W'(len_reg);
    assign len_m1     = len_reg - LEN_W'(1);
    assign len_m1_a   = len_m1[ADDR_W-1:0];
    assign pos_a      = pos_reg[ADDR_W-1:0];
    assign ins_append = (pos_reg == len_ext);
    assign rem_last   = ((pos_reg + CMP_W'(1)) == len_ext);

    always_comb begin
        case (func_reg)
            FUNC_INSERT: cmd_err = (pos_reg > len_ext) || (len_reg == LEN_W'(CAPACITY));
            default:     cmd_err = (pos_reg >= len_ext);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        pos_reg  <= pos_next;
        data_reg <= data_next;
        idx_reg  <= idx_next;
        rdv_reg  <= rdv_next;
        err_reg  <= err_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_err) begin
                    state_next = ST_FINISH;
                end else begin
                    case (func_reg)
                        FUNC_READ:   state_next = ST_RD_WAIT;
                        FUNC_WRITE:  state_next = ST_FINISH;
                        FUNC_INSERT: state_next = ins_append ? ST_FINISH : ST_SHIFT;
                        default:     state_next = rem_last ? ST_FINISH : ST_SHIFT;
                    endcase
                end
            end
            ST_RD_WAIT: state_next = ST_FINISH;
            ST_SHIFT: begin
                if (func_reg == FUNC_INSERT) begin
                    if (idx_reg == pos_a) begin
                        state_next = ST_PLACE;
                    end
                end else if (idx_reg == len_m1_a) begin
                    state_next = ST_FINISH;
                end
            end
            ST_PLACE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // During a shift the write and the read always address different
    // entries, so the store needs no forwarding.
    always_comb begin
        len_next    = len_reg;
        func_next   = func_reg;
        pos_next    = pos_reg;
        data_next   = data_reg;
        idx_next    = idx_reg;
        rdv_next    = rdv_reg;
        err_next    = err_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = pos_a;
        mem_wr_data = data_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = pos_a;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    func_next = cmd_func;
                    pos_next  = CMP_W'(cmd_pos);
                    data_next = cmd_data;
                    rdv_next  = '0;
                    err_next  = 1'b0;
                end
            end
            ST_EXEC: begin
                if (cmd_err) begin
                    err_next = 1'b1;
                end else begin
                    case (func_reg)
                        FUNC_READ: begin
                            mem_rd_en = 1'b1;
                        end
                        FUNC_WRITE: begin
                            mem_wr_en = 1'b1;
                        end
                        FUNC_INSERT: begin
                            if (ins_append) begin
                                mem_wr_en = 1'b1;
                                len_next  = len_reg + LEN_W'(1);
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = len_m1_a;
                                idx_next    = len_m1_a;
                            end
                        end
                        default: begin
                            if (rem_last) begin
                                len_next = len_m1;
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = pos_a + ADDR_W'(1);
                                idx_next    = pos_a + ADDR_W'(1);
                            end
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                rdv_next = mem_rd_data;
            end
            ST_SHIFT: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                if (func_reg == FUNC_INSERT) begin
                    mem_wr_addr = idx_reg + ADDR_W'(1);
                    if (idx_reg != pos_a) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg - ADDR_W'(1);
                        idx_next    = idx_reg - ADDR_W'(1);
                    end
                end else begin
                    mem_wr_addr = idx_reg - ADDR_W'(1);
                    if (idx_reg != len_m1_a) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg + ADDR_W'(1);
                        idx_next    = idx_reg + ADDR_W'(1);
                    end else begin
                        len_next = len_m1;
                    end
                end
            end
            ST_PLACE: begin
                mem_wr_en = 1'b1;
                len_next  = len_reg + LEN_W'(1);
            end
            ST_FINISH: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign res.error        = err_reg;
    assign res.length_after = len_ext[LEN_OUT_W-1:0];
    assign res.read_data    = rdv_reg;

endmodule

`default_nettype wire
